FILE: rtl/gced_pkg.sv
// Shared types and constants for the graph code edge decoder.
package gced_pkg;

  localparam int unsigned LABEL_W = 8;

  // Colour value carried on edges when colored mode is off.
  localparam logic [LABEL_W-1:0] COLOR_NONE = '0;

  // Label that ends the leading run of ignored labels.
  localparam logic [LABEL_W-1:0] LABEL_ZERO = '0;

  typedef struct packed {
    logic [LABEL_W-1:0] source;
    logic [LABEL_W-1:0] target;
    logic [LABEL_W-1:0] color;
  } edge_t;

endpackage

FILE: rtl/graph_code_edge_decoder.sv
// Top level of the graph code edge decoder: label decode, seen map and result queue.
//
// The decoder takes a stream of node labels, one code after another, each code
// fed last element first. The input channel (in_valid/in_ready) carries one
// label per transaction together with code_start, which marks the first label
// of a code and clears all decode state before that label is used. The output
// channel (out_valid/out_ready) carries one directed edge per transaction.
// A label gives at most one edge; most labels give none.
//
// Every label is decoded in the cycle it is accepted, against a flip-flop seen
// map, so one label can be taken in every clock cycle while in_ready is high.
// The edge that a label completes is registered into the result queue when that label is accepted.
// Results pass through a two-entry register queue: the output register and a
// skid register. While the receiver stalls, the block keeps accepting labels
// until both entries hold edges; in_ready then drops until one is taken.
//
// Reset (rst, synchronous) empties the queue, clears the seen map and the
// decode state, and clears colored_mode. The mode register is written through
// cfg_wr_en/cfg_wr_data and should only change while the block is idle.
module graph_code_edge_decoder import gced_pkg::*; #(
  parameter int unsigned LABEL_COUNT = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [LABEL_W-1:0] node_label,
  input  logic               code_start,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [LABEL_W-1:0] edge_source,
  output logic [LABEL_W-1:0] edge_target,
  output logic [LABEL_W-1:0] edge_color
);

  localparam int unsigned IDX_W      = (LABEL_COUNT > 1) ? $clog2(LABEL_COUNT) : 1;
  localparam int unsigned LABEL_VALS = 2 ** LABEL_W;

  // Configuration.
  logic colored_mode;

  // Decode state.
  logic [LABEL_COUNT-1:0] seen_map;
  logic [LABEL_COUNT-1:0] seen_map_next;
  logic [LABEL_W-1:0]     current_node;
  logic [LABEL_W-1:0]     current_node_next;
  logic                   current_valid;
  logic                   current_valid_next;
  logic                   before_start;
  logic                   before_start_next;
  logic                   awaiting_color;
  logic                   awaiting_color_next;
  logic [LABEL_W-1:0]     pending_target;
  logic [LABEL_W-1:0]     pending_target_next;

  // Result queue: output register and skid register.
  edge_t out_edge;
  edge_t skid_edge;
  logic  skid_valid;

  logic  accept;
  logic  pop;
  logic  has_result;
  edge_t new_edge;

  // Map of every label onto its seen map slot. The slot is the label modulo
  // the map size, worked out per entry at elaboration.
  logic [IDX_W-1:0] slot_table [LABEL_VALS];
  logic [IDX_W-1:0] slot;

  for (genvar g = 0; g < LABEL_VALS; g++) begin : g_slot
    assign slot_table[g] = IDX_W'(g % LABEL_COUNT);
  end

  assign slot = slot_table[node_label];

  assign in_ready = !skid_valid;
  assign accept   = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  assign edge_source = out_edge.source;
  assign edge_target = out_edge.target;
  assign edge_color  = out_edge.color;

  // Label decode. A code start first replaces the stored state by its reset
  // values, and the label is then decoded against that cleared state.
  always_comb begin
    logic               seen_bit;
    logic [LABEL_W-1:0] cur_node_e;
    logic               cur_valid_e;
    logic               before_e;
    logic               await_e;
    logic [LABEL_W-1:0] pend_e;

    seen_map_next = code_start ? '0 : seen_map;
    seen_bit      = code_start ? 1'b0 : seen_map[slot];
    cur_node_e    = code_start ? LABEL_ZERO : current_node;
    cur_valid_e   = code_start ? 1'b0 : current_valid;
    before_e      = code_start ? 1'b1 : before_start;
    await_e       = code_start ? 1'b0 : awaiting_color;
    pend_e        = code_start ? LABEL_ZERO : pending_target;

    current_node_next   = cur_node_e;
    current_valid_next  = cur_valid_e;
    before_start_next   = before_e;
    awaiting_color_next = await_e;
    pending_target_next = pend_e;

    has_result      = 1'b0;
    new_edge.source = cur_node_e;
    new_edge.target = node_label;
    new_edge.color  = COLOR_NONE;

    if (before_e && node_label != LABEL_ZERO) begin
      // Leading labels ahead of the first zero are dropped.
    end else begin
      before_start_next = 1'b0;
      if (await_e) begin
        // This label is the colour of the held edge.
        awaiting_color_next = 1'b0;
        has_result          = 1'b1;
        new_edge.target     = pend_e;
        new_edge.color      = node_label;
      end else if (!seen_bit) begin
        seen_map_next[slot] = 1'b1;
        current_node_next   = node_label;
        current_valid_next  = 1'b1;
      end else if (!cur_valid_e) begin
        // A repeat with no current node gives nothing.
      end else if (colored_mode) begin
        awaiting_color_next = 1'b1;
        pending_target_next = node_label;
      end else begin
        has_result = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      colored_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      colored_mode <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_map       <= '0;
      current_node   <= LABEL_ZERO;
      current_valid  <= 1'b0;
      before_start   <= 1'b1;
      awaiting_color <= 1'b0;
      pending_target <= LABEL_ZERO;
    end else if (accept) begin
      seen_map       <= seen_map_next;
      current_node   <= current_node_next;
      current_valid  <= current_valid_next;
      before_start   <= before_start_next;
      awaiting_color <= awaiting_color_next;
      pending_target <= pending_target_next;
    end
  end

  // A new edge can only arrive while the skid register is empty, so the queue
  // never has to take an edge and shift its contents in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_edge   <= skid_edge;
        skid_valid <= 1'b0;
      end else if (accept && has_result) begin
        out_edge <= new_edge;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (accept && has_result) begin
      if (!out_valid) begin
        out_edge  <= new_edge;
        out_valid <= 1'b1;
      end else begin
        skid_edge  <= new_edge;
        skid_valid <= 1'b1;
      end
    end
  end

  // The skid register only fills behind a waiting output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds an edge while the output register is empty");

  // A held edge always has a current node to come from.
  a_await_has_node: assert property (@(posedge clk) disable iff (rst)
    awaiting_color |-> (current_valid && !before_start))
    else $error("colour awaited without a current node");

  // A code that opens with a nonzero label stays in its leading run.
  a_start_nonzero: assert property (@(posedge clk) disable iff (rst)
    (accept && code_start && node_label != LABEL_ZERO) |=>
      (before_start && !current_valid && !awaiting_color))
    else $error("decode state not cleared by a code start");

  // A stalled edge is not dropped from the queue.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("edge lost while the receiver stalls");

  // A full queue takes no label.
  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !out_ready) |=> (skid_valid && !in_ready))
    else $error("queue drained or accepted a label while stalled");

endmodule

FILE: test/graph_code_edge_decoder_tb.sv
// Self-checking testbench for the graph code edge decoder: directed and random label streams.
module graph_code_edge_decoder_tb import gced_pkg::*; ();

  // Size of the seen map in the block under test (its default).
  localparam int unsigned LABEL_COUNT = 256;

  // Share of cycles, out of a hundred, in which each side holds off.
  localparam int unsigned IDLE_PCT = 38;

  // Number of random labels offered in each random phase.
  localparam int unsigned PHASE_LABELS = 280;

  // The edge tracker follows the decode state of the block from the labels
  // that it accepts. It keeps the edges that those labels must give, oldest
  // first, and compares each edge that the block hands out with the oldest one.
  class edge_tracker;
    bit visited [LABEL_COUNT];
    logic [LABEL_W-1:0] head_node;
    bit head_ok;
    bit skipping;
    bit want_color;
    logic [LABEL_W-1:0] held_target;
    bit color_on;
    edge_t edges_due [$];
    int unsigned errors;
    int unsigned edges_seen;
    int unsigned colored_seen;

    function new();
      clear_code();
      color_on = 1'b0;
      errors = 0;
      edges_seen = 0;
      colored_seen = 0;
    endfunction

    function void clear_code();
      foreach (visited[i]) visited[i] = 1'b0;
      head_node = LABEL_ZERO;
      head_ok = 1'b0;
      skipping = 1'b1;
      want_color = 1'b0;
      held_target = LABEL_ZERO;
    endfunction

    function void set_colored(bit on);
      color_on = on;
    endfunction

    // Notes one accepted label transaction and queues the edge it gives, if any.
    function void take_label(logic [LABEL_W-1:0] label, logic start);
      edge_t e;
      if (start) clear_code();
      if (skipping) begin
        if (label != LABEL_ZERO) return;
        skipping = 1'b0;
      end
      if (want_color) begin
        want_color = 1'b0;
        e.source = head_node;
        e.target = held_target;
        e.color = label;
        edges_due = {edges_due, e};
        colored_seen++;
        return;
      end
      if (!visited[label % LABEL_COUNT]) begin
        visited[label % LABEL_COUNT] = 1'b1;
        head_node = label;
        head_ok = 1'b1;
        return;
      end
      if (!head_ok) return;
      if (color_on) begin
        want_color = 1'b1;
        held_target = label;
        return;
      end
      e.source = head_node;
      e.target = label;
      e.color = COLOR_NONE;
      edges_due = {edges_due, e};
    endfunction

    function void check_field(string name, logic [LABEL_W-1:0] want, logic [LABEL_W-1:0] got);
      if (got !== want) begin
        $display("%0t: edge %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compares one edge transaction from the block with the oldest expected edge.
    function void match_edge(edge_t got);
      edge_t want;
      if (edges_due.size() == 0) begin
        $display("%0t: unexpected edge, expected none, actual %0d -> %0d color %0d",
                 $time, got.source, got.target, got.color);
        errors++;
        return;
      end
      want = edges_due.pop_front();
      edges_seen++;
      check_field("source", want.source, got.source);
      check_field("target", want.target, got.target);
      check_field("color", want.color, got.color);
    endfunction

    function int unsigned pending();
      return edges_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [LABEL_W-1:0] node_label = '0;
  logic code_start = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [LABEL_W-1:0] edge_source;
  logic [LABEL_W-1:0] edge_target;
  logic [LABEL_W-1:0] edge_color;

  edge_tracker tracker = new();

  // While calm is set, neither side holds off; this gives one long stretch of
  // back-to-back transactions on both channels.
  bit calm = 1'b0;
  int unsigned labels_sent = 0;
  int unsigned codes_sent = 0;

  graph_code_edge_decoder #(
    .LABEL_COUNT(LABEL_COUNT)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .node_label(node_label),
    .code_start(code_start),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .edge_source(edge_source),
    .edge_target(edge_target),
    .edge_color(edge_color)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver decides at each falling edge whether it takes an edge at the
  // next rising edge. Only one assignment to out_ready happens per step.
  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Edge monitor. Values are read right after the rising edge, before the
  // block's own registers update, so they are the ones the edge saw.
  always @(posedge clk) begin
    edge_t got;
    if (!rst && out_valid && out_ready) begin
      got.source = edge_source;
      got.target = edge_target;
      got.color = edge_color;
      tracker.match_edge(got);
    end
  end

  // Offers one label transaction. The task is entered at a falling edge and
  // returns at a falling edge. Within this task, valid is only lowered by the idle loop, never in
  // the same step in which it is raised for the next label.
  task automatic send_label(input logic [LABEL_W-1:0] label, input logic start);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    node_label <= label;
    code_start <= start;
    do @(posedge clk); while (!in_ready);
    tracker.take_label(label, start);
    labels_sent++;
    @(negedge clk);
  endtask

  // Stops offering labels, waits for every expected edge, then idles before
  // the mode register changes. No label stays in flight inside the block (not
  // even one that gives no edge): it updates the decode state when accepted.
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_mode(input bit on);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= on;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    tracker.set_colored(on);
  endtask

  // One well-formed code, fed last element first: an optional run of leading
  // nonzero labels, the zero that starts decoding, then a mix of random labels and
  // repeats. In colored mode a repeat is usually followed by a colour label;
  // now and then the colour is left out, so the next label is taken as colour.
  task automatic send_code(input bit colored);
    logic [LABEL_W-1:0] used [$];
    logic [LABEL_W-1:0] lbl;
    int unsigned lead;
    int unsigned len;
    bit first;
    lead = ($urandom_range(9) == 0) ? $urandom_range(3, 1) : 0;
    len = ($urandom_range(7) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
    first = 1'b1;
    codes_sent++;
    for (int unsigned i = 0; i < lead; i++) begin
      send_label(LABEL_W'($urandom_range(255, 1)), first);
      first = 1'b0;
    end
    send_label(LABEL_ZERO, first);
    used = {used, LABEL_ZERO};
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(1) == 1) begin
        send_label(used[$urandom_range(used.size() - 1)], 1'b0);
        if (colored && $urandom_range(15) != 0) begin
          send_label(LABEL_W'($urandom_range(255)), 1'b0);
        end
      end else begin
        lbl = LABEL_W'($urandom_range(255));
        send_label(lbl, 1'b0);
        used = {used, lbl};
      end
    end
  endtask

  // A random phase is mostly whole codes, with short bursts of raw labels in
  // between, some of which carry code_start.
  task automatic random_phase(input bit colored);
    int unsigned stop_at;
    stop_at = labels_sent + PHASE_LABELS;
    while (labels_sent < stop_at) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(5, 1)) begin
          send_label(LABEL_W'($urandom_range(255)), $urandom_range(7) == 0);
        end
      end else begin
        send_code(colored);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Plain mode: leading labels before the first zero are skipped, repeats
    // give edges with no colour, and code_start wipes the seen map.
    write_mode(1'b0);
    send_label(8'd5, 1'b1);
    send_label(8'd255, 1'b0);
    send_label(8'd0, 1'b0);
    send_label(8'd3, 1'b0);
    send_label(8'd0, 1'b0);
    send_label(8'd255, 1'b0);
    send_label(8'd3, 1'b0);
    send_label(8'd128, 1'b0);
    send_label(8'd255, 1'b0);
    send_label(8'd0, 1'b1);
    send_label(8'd0, 1'b0);

    // Colored mode: each repeat waits for a colour label, both the top and the
    // bottom of the colour range. The last repeat is dropped by a new code,
    // and the code after it is left holding a repeat at the end of the phase.
    write_mode(1'b1);
    send_label(8'd0, 1'b1);
    send_label(8'd7, 1'b0);
    send_label(8'd0, 1'b0);
    send_label(8'd255, 1'b0);
    send_label(8'd7, 1'b0);
    send_label(8'd0, 1'b0);
    send_label(8'd200, 1'b0);
    send_label(8'd0, 1'b0);
    send_label(8'd0, 1'b1);
    send_label(8'd0, 1'b0);

    // Back to plain mode with a repeat still held: the next label is still
    // taken as its colour. Then a code_start on a nonzero label is skipped.
    write_mode(1'b0);
    send_label(8'd1, 1'b0);
    send_label(8'd170, 1'b1);
    send_label(8'd85, 1'b0);

    write_mode(1'b1);
    random_phase(1'b1);
    write_mode(1'b0);
    random_phase(1'b0);
    write_mode(1'b1);
    calm = 1'b1;
    random_phase(1'b1);
    calm = 1'b0;
    write_mode(1'b0);
    random_phase(1'b0);

    drain();
    repeat (10) @(negedge clk);

    $display("Sent %0d labels in %0d random codes plus directed and raw labels.",
             labels_sent, codes_sent);
    $display("Checked %0d edges, %0d of them carrying a colour label.",
             tracker.edges_seen, tracker.colored_seen);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run of this stimulus.
  initial begin
    #2000000;
    $display("Timed out with %0d edges still expected.", tracker.pending());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
